// ----- sv/bts_pkg.sv -----
`default_nettype none

package bts_pkg;

  localparam int unsigned DefMaxCols  = 256;
  localparam int unsigned DefMaxRows  = 256;
  localparam int unsigned DefFracBits = 16;

  localparam int unsigned CoordW    = 17;
  localparam int unsigned CoordFrac = 16;
  localparam int unsigned SizeW     = 9;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned TexelW    = 3 * ChanW;
  localparam int unsigned NumTaps   = 4;

  localparam logic [CoordW-1:0] CoordOne = CoordW'(1) << CoordFrac;
  localparam logic [SizeW-1:0]  SizeRst  = SizeW'(256);

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              command;
    logic [7:0]        texel_col;
    logic [7:0]        texel_row;
    logic [ChanW-1:0]  in_red;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_blue;
    logic [CoordW-1:0] u_coord;
    logic [CoordW-1:0] v_coord;
  } req_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/bts_texmem.sv -----
`default_nettype none

module bts_texmem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AddrW-1:0]              waddr_i,
  input  wire logic [bts_pkg::TexelW-1:0]    wdata_i,
  input  wire logic [AddrW-1:0]              raddr_i [bts_pkg::NumTaps],
  output      logic [bts_pkg::TexelW-1:0]    rdata_o [bts_pkg::NumTaps]
);
  import bts_pkg::*;

  // one copy per tap, all written together
  for (genvar g = 0; g < NumTaps; g++) begin : g_copy
    logic [TexelW-1:0] mem [Depth];

    always_ff @(posedge clk_i) begin
      if (we_i) begin
        mem[waddr_i] <= wdata_i;
      end
      rdata_o[g] <= mem[raddr_i[g]];
    end
  end

endmodule

`default_nettype wire

// ----- sv/bilinear_texture_sampler_core.sv -----
// Bilinear sampler over an RGB888 texture store.
// A word is accepted at each rising edge with start_i high and busy_o low;
// busy_o stays low, so a new word may be issued every cycle.
// A write word (command = write) stores one texel at texel_col/texel_row if
// that position lies inside tex_width x tex_height; it gives no result.
// A sample word gives one result, flagged by res_valid_o for a single cycle;
// the receiver cannot hold it.
// Throughput is one word per cycle: the store is kept as four copies, one
// per bilinear tap, so all four texels are read in the same cycle.
// Pipeline: input register, coordinate multiply, texel read, weight
// multiply, channel blend into the result register.
// Writes land before any later sample reads, so a sample issued right
// after a write sees the new texel.
// Configuration: cfg_we_i writes register cfg_idx_i (0 width, 1 height);
// change it only while no word is in flight.
// Reset clears the pipeline valid bits and sets both sizes to 256; texel
// contents are undefined until written.
`default_nettype none

module bilinear_texture_sampler_core #(
  parameter int unsigned MAX_COLS  = bts_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS  = bts_pkg::DefMaxRows,
  parameter int unsigned FRAC_BITS = bts_pkg::DefFracBits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output      logic                       busy_o,
  input  wire bts_pkg::req_t              req_i,
  output      logic                       res_valid_o,
  output      bts_pkg::res_t              res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [bts_pkg::SizeW-1:0]  cfg_wdata_i
);
  import bts_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned SCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned SRW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned Depth = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned UW    = CoordW + CW;
  localparam int unsigned VW    = CoordW + RW;
  localparam int unsigned WF    = FRAC_BITS + 1;
  localparam int unsigned WW    = 2 * WF;
  localparam int unsigned PW    = WW + ChanW;
  localparam int unsigned SW    = PW + 2;
  localparam logic [WF-1:0] FracOne = WF'(1) << FRAC_BITS;

  logic [SizeW-1:0] width_q, height_q;
  logic [SCW-1:0]   cols;
  logic [SRW-1:0]   rows;
  logic [CW-1:0]    col_last;
  logic [RW-1:0]    row_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeRst;
      height_q <= SizeRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TEX_WIDTH:  width_q  <= cfg_wdata_i;
        REG_TEX_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) cols = SCW'(1);
    else if (32'(width_q) > MAX_COLS) cols = SCW'(MAX_COLS);
    else cols = SCW'(width_q);
    if (height_q == '0) rows = SRW'(1);
    else if (32'(height_q) > MAX_ROWS) rows = SRW'(MAX_ROWS);
    else rows = SRW'(height_q);
    col_last = CW'(cols - SCW'(1));
    row_last = RW'(rows - SRW'(1));
  end

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  // stage 1: input register
  logic              s1_valid_q;
  req_t              s1_req_q;
  logic [CoordW-1:0] s1_u_q, s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else s1_valid_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    s1_req_q <= req_i;
    s1_u_q   <= (req_i.u_coord > CoordOne) ? CoordOne : req_i.u_coord;
    s1_v_q   <= (req_i.v_coord > CoordOne) ? CoordOne : req_i.v_coord;
  end

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  assign wr_en = s1_valid_q && (cmd_e'(s1_req_q.command) == CMD_WRITE)
                 && (32'(s1_req_q.texel_col) < 32'(cols))
                 && (32'(s1_req_q.texel_row) < 32'(rows));
  assign wr_addr = AW'(32'(s1_req_q.texel_row) * MAX_COLS + 32'(s1_req_q.texel_col));

  // stage 2: scaled coordinates
  logic          s2_valid_q;
  logic [UW-1:0] s2_us_q;
  logic [VW-1:0] s2_vs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else s2_valid_q <= s1_valid_q && (cmd_e'(s1_req_q.command) == CMD_SAMPLE);
  end

  always_ff @(posedge clk_i) begin
    s2_us_q <= UW'(s1_u_q) * UW'(col_last);
    s2_vs_q <= VW'(s1_v_q) * VW'(row_last);
  end

  logic [CW:0]   ci_raw;
  logic [RW:0]   ri_raw;
  logic [CW-1:0] ci, cn;
  logic [RW-1:0] ri, rn;
  logic [FRAC_BITS+CoordFrac-1:0] fs_ext, ft_ext;
  logic [AW-1:0] raddr [NumTaps];

  always_comb begin
    ci_raw = (CW+1)'(s2_us_q >> CoordFrac);
    ri_raw = (RW+1)'(s2_vs_q >> CoordFrac);
    ci = (ci_raw > (CW+1)'(col_last)) ? col_last : CW'(ci_raw);
    ri = (ri_raw > (RW+1)'(row_last)) ? row_last : RW'(ri_raw);
    cn = ((CW+1)'(ci) + (CW+1)'(1) > (CW+1)'(col_last)) ? col_last : CW'(ci + CW'(1));
    rn = ((RW+1)'(ri) + (RW+1)'(1) > (RW+1)'(row_last)) ? row_last : RW'(ri + RW'(1));
    fs_ext = {s2_us_q[CoordFrac-1:0], {FRAC_BITS{1'b0}}};
    ft_ext = {s2_vs_q[CoordFrac-1:0], {FRAC_BITS{1'b0}}};
    raddr[0] = AW'(32'(ri) * MAX_COLS + 32'(ci));
    raddr[1] = AW'(32'(ri) * MAX_COLS + 32'(cn));
    raddr[2] = AW'(32'(rn) * MAX_COLS + 32'(ci));
    raddr[3] = AW'(32'(rn) * MAX_COLS + 32'(cn));
  end

  logic [TexelW-1:0] rdata [NumTaps];

  bts_texmem #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_texmem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({s1_req_q.in_red, s1_req_q.in_green, s1_req_q.in_blue}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // stage 3: texels and fractions
  logic                 s3_valid_q;
  logic [FRAC_BITS-1:0] s3_fs_q, s3_ft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else s3_valid_q <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s3_fs_q <= fs_ext[FRAC_BITS+CoordFrac-1:CoordFrac];
    s3_ft_q <= ft_ext[FRAC_BITS+CoordFrac-1:CoordFrac];
  end

  // stage 4: tap weights
  logic              s4_valid_q;
  logic [WW-1:0]     s4_w_q [NumTaps];
  logic [TexelW-1:0] s4_tex_q [NumTaps];
  logic [WF-1:0]     fs_w, ft_w, fs_c, ft_c;

  always_comb begin
    fs_w = WF'(s3_fs_q);
    ft_w = WF'(s3_ft_q);
    fs_c = FracOne - fs_w;
    ft_c = FracOne - ft_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else s4_valid_q <= s3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s4_w_q[0] <= WW'(fs_c) * WW'(ft_c);
    s4_w_q[1] <= WW'(fs_w) * WW'(ft_c);
    s4_w_q[2] <= WW'(fs_c) * WW'(ft_w);
    s4_w_q[3] <= WW'(fs_w) * WW'(ft_w);
    s4_tex_q  <= rdata;
  end

  // stage 5: blend
  logic [SW-1:0] sum [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int t = 0; t < NumTaps; t++) begin
        sum[ch] = sum[ch] + SW'(PW'(s4_w_q[t]) *
                  PW'(s4_tex_q[t][TexelW-1-ChanW*ch -: ChanW]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_o <= 1'b0;
    else res_valid_o <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    res_o.out_red   <= sum[0][2*FRAC_BITS +: ChanW];
    res_o.out_green <= sum[1][2*FRAC_BITS +: ChanW];
    res_o.out_blue  <= sum[2][2*FRAC_BITS +: ChanW];
  end

  a_sample_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.command == CMD_SAMPLE) |-> ##5 res_valid_o)
    else $error("sample word lost");

  a_write_gives_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.command == CMD_WRITE) |-> ##5 !res_valid_o)
    else $error("write word produced a result");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (ci <= cn && cn <= col_last && ri <= rn && rn <= row_last))
    else $error("tap index outside texture");

endmodule

`default_nettype wire
